>>> rtl/bmp_pkg.sv
// Shared types, constants and helpers for the bank mapper with protected RAM.
// Used by every module of the block but bmp_ram; depends on nothing else.
`timescale 1ns / 1ps

package bmp_pkg;

  // Sizes that the field widths and the RAM fix.
  localparam int unsigned BMP_BANK_BITS   = 8;
  localparam int unsigned BMP_RAM_BYTES   = 128;
  localparam int unsigned BMP_RAM_AW      = $clog2(BMP_RAM_BYTES);
  localparam int unsigned BMP_MAP_W       = 21;
  localparam int unsigned BMP_QUEUE_DEPTH = 2;
  localparam int unsigned BMP_CFG_IDX_W   = 2;

  // Bus address map.
  localparam logic [15:0] ADDR_REG_LO    = 16'h7EF0;
  localparam logic [15:0] ADDR_REG_HI    = 16'h7FFF;
  localparam logic [15:0] ADDR_CHR2K     = 16'h7EF0;
  localparam logic [15:0] ADDR_CHR1K_A   = 16'h7EF2;
  localparam logic [15:0] ADDR_CHR1K_B   = 16'h7EF4;
  localparam logic [15:0] ADDR_MIRROR    = 16'h7EF6;
  localparam logic [15:0] ADDR_UNLOCK    = 16'h7EF8;
  localparam logic [15:0] ADDR_PRG0      = 16'h7EFA;
  localparam logic [15:0] ADDR_PRG1      = 16'h7EFC;
  localparam logic [15:0] ADDR_PRG2      = 16'h7EFE;
  localparam logic [15:0] ADDR_RD_LO     = 16'h7EF8;
  localparam logic [15:0] ADDR_UNLOCK_RD = 16'h7FE8;
  localparam logic [7:0]  RAM_PAGE       = 8'h7F;

  localparam logic [7:0] UNLOCK_KEY  = 8'hA3;
  localparam logic [7:0] LOCKED_DATA = 8'h7F;

  typedef enum logic [1:0] {
    FUNC_CPU_WRITE = 2'd0,
    FUNC_CPU_READ  = 2'd1,
    FUNC_MAP_PAT   = 2'd2,
    FUNC_MAP_PRG   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    MIR_HORIZ   = 2'd0,
    MIR_VERT    = 2'd1,
    MIR_SINGLE0 = 2'd2,
    MIR_SINGLE1 = 2'd3
  } mirror_e;

  typedef enum logic [BMP_CFG_IDX_W-1:0] {
    CFG_VARIANT     = 2'd0,
    CFG_PRG_LIMIT   = 2'd1,
    CFG_CHR1K_LIMIT = 2'd2,
    CFG_CHR2K_LIMIT = 2'd3
  } cfg_idx_e;

  // Classified operation handed from the front end to the back end.
  typedef enum logic [3:0] {
    OP_IGNORE    = 4'd0,
    OP_CHR2K     = 4'd1,
    OP_CHR1K     = 4'd2,
    OP_MIRROR    = 4'd3,
    OP_UNLOCK    = 4'd4,
    OP_PRG       = 4'd5,
    OP_RAM_WR    = 4'd6,
    OP_RD_BUS    = 4'd7,
    OP_RD_UNLOCK = 4'd8,
    OP_RD_RAM    = 4'd9,
    OP_MAP_PAT   = 4'd10,
    OP_MAP_PRG   = 4'd11
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [7:0]  bus;
  } cmd_t;

  typedef struct packed {
    logic                     we;
    logic [BMP_CFG_IDX_W-1:0] index;
    logic [7:0]               data;
  } cfg_wr_t;

  // A bank number above the limit is folded onto the limit by masking.
  function automatic logic [7:0] bank_limit(input logic [7:0] v, input logic [7:0] lim);
    logic [7:0] r;
    r = (v > lim) ? (v & lim) : v;
    return r;
  endfunction

endpackage

>>> rtl/bmp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

module bmp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bmp_front.sv
// Front end: takes bus accesses and classifies them into commands.
// Depends on bmp_pkg.
`timescale 1ns / 1ps

module bmp_front import bmp_pkg::*; (
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  open_bus_i,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output cmd_t        cmd_o
);

  logic [15:0] base;
  logic        in_reg_range;
  logic        in_rd_range;
  op_e         op;

  assign base         = {address_i[15:1], 1'b0};
  assign in_reg_range = (address_i >= ADDR_REG_LO) && (address_i <= ADDR_REG_HI);
  assign in_rd_range  = (address_i >= ADDR_RD_LO) && (address_i <= ADDR_REG_HI);

  always_comb begin
    op = OP_IGNORE;
    unique case (func_e'(func_i))
      FUNC_CPU_WRITE: begin
        priority if (!in_reg_range)                                op = OP_IGNORE;
        else if (base == ADDR_CHR2K)                               op = OP_CHR2K;
        else if (base == ADDR_CHR1K_A || base == ADDR_CHR1K_B)     op = OP_CHR1K;
        else if (base == ADDR_MIRROR)                              op = OP_MIRROR;
        else if (base == ADDR_UNLOCK)                              op = OP_UNLOCK;
        else if (base == ADDR_PRG0 || base == ADDR_PRG1 || base == ADDR_PRG2) op = OP_PRG;
        else if (address_i[15:8] == RAM_PAGE)                      op = OP_RAM_WR;
        else                                                       op = OP_IGNORE;
      end
      FUNC_CPU_READ: begin
        priority if (!in_rd_range)             op = OP_RD_BUS;
        else if (base == ADDR_UNLOCK_RD)       op = OP_RD_UNLOCK;
        else if (address_i[15:8] == RAM_PAGE)  op = OP_RD_RAM;
        else                                   op = OP_RD_BUS;
      end
      FUNC_MAP_PAT: op = OP_MAP_PAT;
      FUNC_MAP_PRG: op = OP_MAP_PRG;
      default:      op = OP_IGNORE;
    endcase
  end

  assign cmd_o.op   = op;
  assign cmd_o.addr = address_i;
  assign cmd_o.data = write_data_i;
  assign cmd_o.bus  = open_bus_i;

  assign cmd_valid_o = in_valid_i;
  assign in_ready_o  = cmd_ready_i;

endmodule

>>> rtl/bmp_queue.sv
// Short command queue between the front end and the back end.
// Depends on bmp_pkg.
`timescale 1ns / 1ps

module bmp_queue import bmp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  localparam int unsigned QAW = (BMP_QUEUE_DEPTH > 1) ? $clog2(BMP_QUEUE_DEPTH) : 1;
  localparam int unsigned QCW = $clog2(BMP_QUEUE_DEPTH + 1);
  localparam logic [QAW-1:0] LAST_PTR = QAW'(BMP_QUEUE_DEPTH - 1);
  localparam logic [QCW-1:0] FULL_CNT = QCW'(BMP_QUEUE_DEPTH);

  cmd_t           mem_q [BMP_QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] cnt_q, cnt_d;
  logic           push, pop;

  assign push_ready_o = (cnt_q != FULL_CNT);
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

>>> rtl/bmp_back.sv
// Back end: holds the bank registers, configuration and protected RAM,
// executes commands and registers the result. Depends on bmp_pkg, bmp_ram.
`timescale 1ns / 1ps

module bmp_back import bmp_pkg::*; #(
  parameter int unsigned BANK_BITS = BMP_BANK_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_wr_t              cfg_i,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  cmd_t                 cmd_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output logic [7:0]           res_read_data_o,
  output logic [BMP_MAP_W-1:0] res_mapped_o,
  output logic [1:0]           res_mirror_o
);

  logic [BANK_BITS-1:0] pat_q [8];
  logic [BANK_BITS-1:0] pat_d [8];
  logic [BANK_BITS-1:0] prg_q [3];
  logic [BANK_BITS-1:0] prg_d [3];
  mirror_e              mirror_q, mirror_d;
  logic [7:0]           unlock_q, unlock_d;
  logic                 variant_q, variant_d;
  logic [7:0]           prg_lim_q, prg_lim_d;
  logic [7:0]           chr1k_lim_q, chr1k_lim_d;
  logic [6:0]           chr2k_lim_q, chr2k_lim_d;
  logic [BMP_RAM_BYTES-1:0] ram_vld_q, ram_vld_d;

  logic                 out_valid_q;
  logic [7:0]           out_rd_q;
  logic [BMP_MAP_W-1:0] out_map_q;
  mirror_e              out_mirror_q;
  logic                 out_ram_sel_q;
  logic                 out_ram_vld_q;

  logic                  out_free, fire;
  logic [7:0]            lim2k, lim1k, limprg, p2k_even, p2k_odd;
  logic [BANK_BITS-1:0]  prg_bank;
  logic [BMP_RAM_AW-1:0] ram_addr;
  logic                  unlocked;
  logic                  ram_we, ram_re, ram_sel;
  logic [7:0]            rd_val, ram_rdata;
  logic [BMP_MAP_W-1:0]  map_val;

  assign out_free    = !out_valid_q || res_ready_i;
  assign fire        = cmd_valid_i && out_free;
  assign cmd_ready_o = out_free;

  assign ram_addr = cmd_i.addr[BMP_RAM_AW-1:0];
  assign unlocked = (unlock_q == UNLOCK_KEY);
  assign lim2k    = bank_limit({1'b0, cmd_i.data[7:1]}, {1'b0, chr2k_lim_q});
  assign lim1k    = bank_limit(cmd_i.data, chr1k_lim_q);
  assign limprg   = bank_limit(cmd_i.data, prg_lim_q);
  assign p2k_even = {lim2k[6:0], 1'b0};
  assign p2k_odd  = {lim2k[6:0], 1'b1};

  always_comb begin
    unique case (cmd_i.addr[14:13])
      2'd0:    prg_bank = prg_q[0];
      2'd1:    prg_bank = prg_q[1];
      2'd2:    prg_bank = prg_q[2];
      default: prg_bank = prg_lim_q[BANK_BITS-1:0];
    endcase
  end

  always_comb begin
    pat_d       = pat_q;
    prg_d       = prg_q;
    mirror_d    = mirror_q;
    unlock_d    = unlock_q;
    variant_d   = variant_q;
    prg_lim_d   = prg_lim_q;
    chr1k_lim_d = chr1k_lim_q;
    chr2k_lim_d = chr2k_lim_q;
    ram_vld_d   = ram_vld_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_sel     = 1'b0;
    rd_val      = '0;
    map_val     = '0;

    if (cfg_i.we) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_VARIANT: begin
          variant_d = cfg_i.data[0];
          mirror_d  = cfg_i.data[0] ? MIR_SINGLE0 : MIR_HORIZ;
        end
        CFG_PRG_LIMIT:   prg_lim_d   = cfg_i.data;
        CFG_CHR1K_LIMIT: chr1k_lim_d = cfg_i.data;
        CFG_CHR2K_LIMIT: chr2k_lim_d = cfg_i.data[6:0];
        default: ;
      endcase
    end else if (fire) begin
      unique case (cmd_i.op)
        OP_CHR2K: begin
          if (variant_q) begin
            mirror_d = cmd_i.data[7] ? MIR_SINGLE1 : MIR_SINGLE0;
          end
          pat_d[{1'b0, cmd_i.addr[0], 1'b0}] = p2k_even[BANK_BITS-1:0];
          pat_d[{1'b0, cmd_i.addr[0], 1'b1}] = p2k_odd[BANK_BITS-1:0];
        end
        OP_CHR1K: begin
          if (variant_q) begin
            mirror_d = cmd_i.data[7] ? MIR_SINGLE1 : MIR_SINGLE0;
          end
          pat_d[cmd_i.addr[2:0] + 3'd2] = lim1k[BANK_BITS-1:0];
        end
        OP_MIRROR: begin
          if (!variant_q) begin
            mirror_d = cmd_i.data[0] ? MIR_VERT : MIR_HORIZ;
          end
        end
        OP_UNLOCK: unlock_d = cmd_i.data;
        OP_PRG: begin
          unique case (cmd_i.addr[2:1])
            2'd1:    prg_d[0] = limprg[BANK_BITS-1:0];
            2'd2:    prg_d[1] = limprg[BANK_BITS-1:0];
            2'd3:    prg_d[2] = limprg[BANK_BITS-1:0];
            default: ;
          endcase
        end
        OP_RAM_WR: begin
          if (unlocked) begin
            ram_we              = 1'b1;
            ram_vld_d[ram_addr] = 1'b1;
          end
        end
        OP_RD_BUS:    rd_val = cmd_i.bus;
        OP_RD_UNLOCK: rd_val = unlock_q;
        OP_RD_RAM: begin
          if (unlocked) begin
            ram_re  = 1'b1;
            ram_sel = 1'b1;
          end else begin
            rd_val = LOCKED_DATA;
          end
        end
        OP_MAP_PAT: begin
          map_val = BMP_MAP_W'({pat_q[cmd_i.addr[12:10]], cmd_i.addr[9:0]});
        end
        OP_MAP_PRG: begin
          map_val = BMP_MAP_W'({prg_bank, cmd_i.addr[12:0]});
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        pat_q[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        prg_q[i] <= '0;
      end
      mirror_q    <= MIR_HORIZ;
      unlock_q    <= '0;
      variant_q   <= 1'b0;
      prg_lim_q   <= 8'hFF;
      chr1k_lim_q <= 8'hFF;
      chr2k_lim_q <= 7'h7F;
      ram_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pat_q       <= pat_d;
      prg_q       <= prg_d;
      mirror_q    <= mirror_d;
      unlock_q    <= unlock_d;
      variant_q   <= variant_d;
      prg_lim_q   <= prg_lim_d;
      chr1k_lim_q <= chr1k_lim_d;
      chr2k_lim_q <= chr2k_lim_d;
      ram_vld_q   <= ram_vld_d;
      if (out_free) begin
        out_valid_q <= cmd_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_rd_q      <= rd_val;
      out_map_q     <= map_val;
      out_mirror_q  <= mirror_d;
      out_ram_sel_q <= ram_sel;
      out_ram_vld_q <= ram_vld_q[ram_addr];
    end
  end

  bmp_ram #(
    .WIDTH (8),
    .DEPTH (BMP_RAM_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (cmd_i.data),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  // A RAM byte never written since reset reads as zero.
  assign res_valid_o     = out_valid_q;
  assign res_read_data_o = out_ram_sel_q ? (out_ram_vld_q ? ram_rdata : 8'h00) : out_rd_q;
  assign res_mapped_o    = out_map_q;
  assign res_mirror_o    = out_mirror_q;

endmodule

>>> rtl/bank_mapper_with_protected_ram_top.sv
// Top level of the bank mapper with protected RAM.
// Depends on bmp_pkg, bmp_front, bmp_queue, bmp_back and bmp_ram.
`timescale 1ns / 1ps

// The block answers bus accesses arriving as transfers on the slave stream.
// tuser carries the access kind (cpu write, cpu read, pattern translate,
// program translate); tdata carries the bus address, the write byte and the
// open-bus byte. Every accepted transfer produces exactly one result
// transfer on the master stream with the read byte, the translated rom
// address and the current mirroring.
// The configuration port is a plain write port: when cfg_we_i is high at a
// rising edge, register cfg_index_i (variant, program limit, 1K pattern
// limit, 2K pattern limit) takes cfg_data_i. Write it only while idle.
// An accepted transfer is written into the command queue and then executed
// by the back end, whose result register (fed by the registered RAM read)
// drives the master stream.
// Throughput is one transfer per cycle while the receiver does not stall;
// commands execute as taken, and the RAM has a write and a read port.
// When the receiver stalls, the result register holds and the back end
// stops; the two-entry queue then fills and s_axis_tready falls.
// Reset clears the bank registers, mirroring and unlock byte, sets the limits
// to their highest values and clears the RAM valid bits so unwritten RAM
// bytes read as zero; transfers are taken straight after reset.
module bank_mapper_with_protected_ram_top import bmp_pkg::*; #(
  parameter int unsigned BANK_BITS = BMP_BANK_BITS
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Configuration write port
  input  logic                     cfg_we_i,
  input  logic [BMP_CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]               cfg_data_i,
  // Slave stream: bus accesses
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [31:0]              s_axis_tdata,  // address[15:0], write_data[23:16], open_bus[31:24]
  input  logic [1:0]               s_axis_tuser,  // func[1:0]
  // Master stream: results
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [31:0]              m_axis_tdata   // read_data[7:0], mapped_address[28:8],
                                                  // mirroring[30:29], zero[31]
);

  cfg_wr_t              cfg;
  cmd_t                 front_cmd, back_cmd;
  logic                 front_valid, front_ready;
  logic                 back_valid, back_ready;
  logic [7:0]           res_read_data;
  logic [BMP_MAP_W-1:0] res_mapped;
  logic [1:0]           res_mirror;

  assign cfg.we    = cfg_we_i;
  assign cfg.index = cfg_index_i;
  assign cfg.data  = cfg_data_i;

  bmp_front u_front (
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .func_i       (s_axis_tuser),
    .address_i    (s_axis_tdata[15:0]),
    .write_data_i (s_axis_tdata[23:16]),
    .open_bus_i   (s_axis_tdata[31:24]),
    .cmd_valid_o  (front_valid),
    .cmd_ready_i  (front_ready),
    .cmd_o        (front_cmd)
  );

  bmp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_cmd_o    (back_cmd)
  );

  bmp_back #(
    .BANK_BITS (BANK_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_valid_i     (back_valid),
    .cmd_ready_o     (back_ready),
    .cmd_i           (back_cmd),
    .res_valid_o     (m_axis_tvalid),
    .res_ready_i     (m_axis_tready),
    .res_read_data_o (res_read_data),
    .res_mapped_o    (res_mapped),
    .res_mirror_o    (res_mirror)
  );

  assign m_axis_tdata = {1'b0, res_mirror, res_mapped, res_read_data};

endmodule
